/* sv/cbm_pkg.sv */
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

  localparam int unsigned RAM_BYTES_DEF = 8192;
  localparam int unsigned BANK_BITS_DEF = 8;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ROM_AW = 21;
  localparam int unsigned CNT_W  = 16;

  localparam logic [ADDR_W-1:0] WIN_LO       = 16'hB800;
  localparam logic [ADDR_W-1:0] WIN_HI       = 16'hD800;
  localparam logic [ADDR_W-1:0] PRG_LO       = 16'h8000;
  localparam logic [ADDR_W-1:0] WRAM_LO      = 16'h6000;
  localparam logic [3:0]        IRQ_PAGE     = 4'hE;
  localparam logic [3:0]        BANK_PAGE    = 4'hF;
  localparam logic [CNT_W-1:0]  TARGET_RESET = 16'd7560;
  localparam logic [1:0]        FIXED_BANK   = 2'd3;
  localparam int unsigned       IRQ_EN_BIT   = 1;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ROM    = 2'd1,
    KIND_RAM_RD = 2'd2,
    KIND_RAM_WR = 2'd3
  } kind_e;

  // control to the irq timer
  typedef struct packed {
    logic tick;
    logic ctl_wr;
    logic ctl_en;
  } irq_ctl_t;

  // everything the decoder derives from one beat (ram index kept separately)
  typedef struct packed {
    kind_e             kind;
    logic [ROM_AW-1:0] rom_addr;
    logic              ram_rd;
    logic              ram_wr;
    logic              bank_wr;
    irq_ctl_t          irq;
  } dec_t;

endpackage

/* sv/cartridge_bank_mapper_with_irq_timer_unit.sv */
// top level of the cartridge bank mapper with cpu cycle irq timer
//
// usage:
//   s_axis carries one cpu bus beat per cycle while ready: tuser is the function
//   (read, write or cycle tick), tdata the address and write byte
//   m_axis returns one result beat per input beat, in order: tuser is the
//   access kind, tdata the rom byte address, ram byte and irq line
//   cfg writes the irq target; it is always ready and must only be used
//   while no beat is in flight
// latency and throughput:
//   a result shows on m_axis in the cycle after its input beat is taken;
//   one beat per cycle sustained while m_axis_tready_i is high, set by the
//   single output register and the one-port window ram
// reset:
//   bank and timer state clear, the irq target loads TARGET_RESET, and the
//   8 KiB window ram (by default) is swept to zero, one byte a cycle,
//   while s_axis_tready_o stays low
// stall:
//   while m_axis_tready_i is low and a result is pending, the result holds and s_axis takes no beat
module cartridge_bank_mapper_with_irq_timer_unit #(
  parameter int unsigned RAM_BYTES = cbm_pkg::RAM_BYTES_DEF,
  parameter int unsigned BANK_BITS = cbm_pkg::BANK_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // cpu_address[15:0], write_data[23:16]
  input  logic [1:0]  s_axis_tuser_i,   // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // rom_address[20:0], read_data[28:21],
                                        // irq_asserted[29], zero[31:30]
  output logic [1:0]  m_axis_tuser_o,   // access_kind[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i        // irq_target
);
  import cbm_pkg::*;

  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

  // input beat fields
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wdata;
  logic              in_acc;

  assign addr  = s_axis_tdata_i[15:0];
  assign wdata = s_axis_tdata_i[23:16];

  // mapper registers
  logic [BANK_BITS-1:0] bank_q;
  logic [CNT_W-1:0]     target_q;

  // decode of the incoming beat
  dec_t              dec;
  logic [RAM_AW-1:0] ram_idx;
  logic              ram_busy;
  logic [DATA_W-1:0] ram_rdata;
  logic              irq_d;

  // output register
  logic              out_vld_q;
  kind_e             kind_q;
  logic [ROM_AW-1:0] rom_q;
  logic              irq_q;
  logic [DATA_W-1:0] rd_byte;

  // a beat enters when the ram sweep is done and the result slot is free or draining this cycle
  assign s_axis_tready_o = !ram_busy && (!out_vld_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  cbm_decode #(
    .BANK_BITS (BANK_BITS),
    .RAM_AW    (RAM_AW)
  ) u_decode (
    .func_i    (s_axis_tuser_i),
    .addr_i    (addr),
    .data_i    (wdata),
    .bank_i    (bank_q),
    .dec_o     (dec),
    .ram_idx_o (ram_idx)
  );

  // read and write both happen at the accept edge, so a read right after
  // a write to the same byte already sees the new value
  cbm_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_acc && dec.ram_wr),
    .re_i    (in_acc && dec.ram_rd),
    .idx_i   (ram_idx),
    .wdata_i (wdata),
    .rdata_o (ram_rdata),
    .busy_o  (ram_busy)
  );

  cbm_irq_timer u_irq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_acc),
    .ctl_i    (dec.irq),
    .target_i (target_q),
    .line_d_o (irq_d)
  );

  // irq target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  // bank select, only the low BANK_BITS bits are ever used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
    end else if (in_acc && dec.bank_wr) begin
      bank_q <= wdata[BANK_BITS-1:0];
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload, ram byte sits in the ram's own read register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= dec.kind;
      rom_q  <= dec.rom_addr;
      irq_q  <= irq_d;
    end
  end

  assign rd_byte = (kind_q == KIND_RAM_RD) ? ram_rdata : '0;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {2'b00, irq_q, rd_byte, rom_q};

  // no beat is taken while the ram sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_busy |-> !s_axis_tready_o)
    else $error("beat accepted during ram clear sweep");

  // every accepted beat produces a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  // the irq only drops after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && $past(m_axis_tvalid_o) && $fell(irq_q)) |-> $past(in_acc))
    else $error("irq dropped without a beat");

  // only rom reads carry a rom address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && kind_q != KIND_ROM) |-> (rom_q == '0))
    else $error("rom address on non rom result");

endmodule

/* sv/cbm_decode.sv */
// bus access decoder: address windows, rom address forming, register writes
module cbm_decode #(
  parameter int unsigned BANK_BITS = 8,
  parameter int unsigned RAM_AW    = 13
) (
  input  logic [1:0]                    func_i,
  input  logic [cbm_pkg::ADDR_W-1:0]    addr_i,
  input  logic [cbm_pkg::DATA_W-1:0]    data_i,
  input  logic [BANK_BITS-1:0]          bank_i,
  output cbm_pkg::dec_t                 dec_o,
  output logic [RAM_AW-1:0]             ram_idx_o
);
  import cbm_pkg::*;

  logic             in_win;
  logic [ADDR_W-1:0] win_off;

  assign in_win    = (addr_i >= WIN_LO) && (addr_i < WIN_HI);
  assign win_off   = addr_i - WIN_LO;
  assign ram_idx_o = win_off[RAM_AW-1:0];

  always_comb begin
    dec_o          = '0;
    dec_o.kind     = KIND_NONE;
    unique case (func_i)
      FUNC_READ: begin
        if (in_win) begin
          dec_o.kind   = KIND_RAM_RD;
          dec_o.ram_rd = 1'b1;
        end else if (addr_i >= PRG_LO) begin
          dec_o.kind     = KIND_ROM;
          dec_o.rom_addr = (ROM_AW'(FIXED_BANK) << 15) | ROM_AW'(addr_i[14:0]);
        end else if (addr_i >= WRAM_LO) begin
          dec_o.kind     = KIND_ROM;
          dec_o.rom_addr = (ROM_AW'(bank_i) << 13) | ROM_AW'(addr_i[12:0]);
        end
      end
      FUNC_WRITE: begin
        if (in_win) begin
          dec_o.kind   = KIND_RAM_WR;
          dec_o.ram_wr = 1'b1;
        end else if (addr_i[15:12] == IRQ_PAGE) begin
          dec_o.irq.ctl_wr = 1'b1;
          dec_o.irq.ctl_en = data_i[IRQ_EN_BIT];
        end else if (addr_i[15:12] == BANK_PAGE) begin
          dec_o.bank_wr = 1'b1;
        end
      end
      FUNC_TICK: dec_o.irq.tick = 1'b1;
      default:   dec_o.kind = KIND_NONE;
    endcase
  end

endmodule

/* sv/cbm_irq_timer.sv */
// cpu cycle counter with compare-match interrupt
module cbm_irq_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  cbm_pkg::irq_ctl_t           ctl_i,
  input  logic [cbm_pkg::CNT_W-1:0]   target_i,
  output logic                        line_d_o
);
  import cbm_pkg::*;

  logic             en_q, en_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             line_q, line_d;

  always_comb begin
    en_d   = en_q;
    cnt_d  = cnt_q;
    line_d = line_q;
    if (ctl_i.ctl_wr) begin
      en_d   = ctl_i.ctl_en;
      cnt_d  = '0;
      line_d = 1'b0;
    end else if (ctl_i.tick && en_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_d == target_i) begin
        line_d = 1'b1;
      end
    end
  end

  assign line_d_o = line_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      cnt_q  <= '0;
      line_q <= 1'b0;
    end else if (step_i) begin
      en_q   <= en_d;
      cnt_q  <= cnt_d;
      line_q <= line_d;
    end
  end

endmodule

/* sv/cbm_ram.sv */
// window ram with registered read and a zero fill sweep after reset
module cbm_ram #(
  parameter int unsigned RAM_BYTES = 8192
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic                               re_i,
  input  logic [$clog2(RAM_BYTES)-1:0]       idx_i,
  input  logic [cbm_pkg::DATA_W-1:0]         wdata_i,
  output logic [cbm_pkg::DATA_W-1:0]         rdata_o,
  output logic                               busy_o
);
  import cbm_pkg::*;

  localparam int unsigned AW = $clog2(RAM_BYTES);

  logic [DATA_W-1:0] mem [RAM_BYTES];
  logic [AW:0]       clr_q, clr_d;
  logic [DATA_W-1:0] rdata_q;

  assign busy_o = (clr_q != (AW+1)'(RAM_BYTES));
  assign clr_d  = clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem[clr_q[AW-1:0]] <= '0;
    end else if (we_i) begin
      mem[idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[idx_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/mapper_scoreboard_pkg.sv */
// scoreboard class holding the mapper prediction and the queue of expected result beats
package mapper_scoreboard_pkg;
  import cbm_pkg::*;

  typedef struct packed {
    kind_e              kind;
    logic [ROM_AW-1:0]  rom_addr;
    logic [DATA_W-1:0]  ram_byte;
    logic               irq;
  } bus_result_t;

  class mapper_scoreboard;
    logic [CNT_W-1:0]  irq_target;
    logic [7:0]        bank_select;
    logic              irq_enable;
    logic [CNT_W-1:0]  cycle_count;
    logic              irq_line;
    logic [DATA_W-1:0] window_ram [RAM_BYTES_DEF];
    bus_result_t       expected_results [$];
    int unsigned       mismatches;

    function new();
      irq_target  = TARGET_RESET;
      bank_select = '0;
      irq_enable  = 1'b0;
      cycle_count = '0;
      irq_line    = 1'b0;
      foreach (window_ram[i]) window_ram[i] = '0;
      mismatches  = 0;
    endfunction

    function void set_target(logic [CNT_W-1:0] value);
      irq_target = value;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // next state and result beat of the mapper for one bus beat
    function bus_result_t map_access(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] data);
      bus_result_t       res;
      logic [ADDR_W-1:0] offset;
      logic [7:0]        bank_keep;
      logic              in_window;
      res       = '0;
      res.kind  = KIND_NONE;
      offset    = addr - WIN_LO;
      bank_keep = bank_select & 8'((1 << BANK_BITS_DEF) - 1);
      in_window = (addr >= WIN_LO) && (addr < WIN_HI);
      case (func)
        FUNC_READ: begin
          if (in_window) begin
            res.kind     = KIND_RAM_RD;
            res.ram_byte = window_ram[offset[12:0]];
          end else if (addr >= PRG_LO) begin
            res.kind     = KIND_ROM;
            res.rom_addr = {4'd0, FIXED_BANK, addr[14:0]};
          end else if (addr >= WRAM_LO) begin
            res.kind     = KIND_ROM;
            res.rom_addr = {bank_keep, addr[12:0]};
          end
        end
        FUNC_WRITE: begin
          if (in_window) begin
            res.kind = KIND_RAM_WR;
            window_ram[offset[12:0]] = data;
          end else if (addr[15:12] == IRQ_PAGE) begin
            irq_enable  = data[IRQ_EN_BIT];
            cycle_count = '0;
            irq_line    = 1'b0;
          end else if (addr[15:12] == BANK_PAGE) begin
            bank_select = data;
          end
        end
        FUNC_TICK: begin
          if (irq_enable) begin
            cycle_count = cycle_count + 1'b1;
            if (cycle_count == irq_target) irq_line = 1'b1;
          end
        end
        default: ;
      endcase
      res.irq = irq_line;
      return res;
    endfunction

    function void note_access(logic [1:0] func, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data);
      expected_results.push_back(map_access(func, addr, data));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] kind, logic [ROM_AW-1:0] rom_addr,
                      logic [DATA_W-1:0] ram_byte, logic irq);
      bus_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no expected result pending");
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("access_kind got %0d want %0d", kind, want.kind));
      if (rom_addr !== want.rom_addr)
        report_mismatch($sformatf("rom_address got %h want %h", rom_addr, want.rom_addr));
      if (ram_byte !== want.ram_byte)
        report_mismatch($sformatf("read_data got %h want %h", ram_byte, want.ram_byte));
      if (irq !== want.irq)
        report_mismatch($sformatf("irq_asserted got %b want %b", irq, want.irq));
    endtask
  endclass

endpackage

/* sim/cartridge_bank_mapper_with_irq_timer_unit_tb.sv */
// testbench for the cartridge bank mapper: directed and random beats checked in order
module cartridge_bank_mapper_with_irq_timer_unit_tb;
  import cbm_pkg::*;
  import mapper_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the unused function code, passed through as a no-op
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // cpu_address[15:0], write_data[23:16]
  logic [1:0]  s_axis_tuser_i;   // func[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // rom_address[20:0], read_data[28:21], irq_asserted[29]
  logic [1:0]  m_axis_tuser_o;   // access_kind[1:0]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;       // irq_target

  // percent of cycles the sender idles and the receiver stalls
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;

  mapper_scoreboard sb = new();

  cartridge_bank_mapper_with_irq_timer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop; the slowest legal run (ram sweep, stalled random phases)
  // stays far below this
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random back-pressure chosen on the falling edge
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // every accepted result beat goes against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tuser_o, m_axis_tdata_o[20:0], m_axis_tdata_o[28:21],
                      m_axis_tdata_o[29]);
  end

  // one bus beat; idles first at the current gap rate, valid stays up until taken
  task automatic send_access(logic [1:0] func, logic [15:0] addr, logic [7:0] data);
    @(negedge clk_i);
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {data, addr};
    s_axis_tuser_i  <= func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_access(func, addr, data);
  endtask

  // drop valid and let every predicted result come back, plus the output stage
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_target(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_target(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random beat mix: ticks dominate so the timer reaches small targets,
  // irq-page writes are rare so the counter gets a chance to run
  task automatic random_access();
    int unsigned       pick;
    int unsigned       sub;
    logic [15:0]       addr;
    logic [7:0]        data;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    data = 8'($urandom);
    if (pick < 40) begin
      send_access(FUNC_TICK, 16'($urandom), data);
    end else if (pick < 65) begin
      case (sub % 4)
        0: addr = 16'($urandom);
        1: addr = WIN_LO + 16'($urandom_range(0, RAM_BYTES_DEF - 1));
        2: addr = WRAM_LO + 16'($urandom_range(0, 16'h1FFF));
        default: addr = PRG_LO | 16'($urandom_range(0, 16'h7FFF));
      endcase
      send_access(FUNC_READ, addr, data);
    end else if (pick < 96) begin
      if (sub < 55) begin
        addr = WIN_LO + 16'($urandom_range(0, RAM_BYTES_DEF - 1));
      end else if (sub < 61) begin
        addr = {IRQ_PAGE, 12'($urandom)};
        // mostly enable the timer
        if ($urandom_range(9) < 8) data[IRQ_EN_BIT] = 1'b1;
      end else if (sub < 80) begin
        addr = {BANK_PAGE, 12'($urandom)};
      end else begin
        addr = 16'($urandom);
      end
      send_access(FUNC_WRITE, addr, data);
    end else begin
      send_access(FUNC_UNUSED, 16'($urandom), data);
    end
  endtask

  initial begin
    int unsigned phase;
    logic [15:0] target;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: region edges, ram window bounds, ignored writes, timer control;
    // target is still at its reset value here so the irq stays low
    send_access(FUNC_READ,  16'h0000, 8'h00);       // below the rom windows
    send_access(FUNC_READ,  16'h5FFF, 8'hFF);
    send_access(FUNC_READ,  WRAM_LO, 8'h00);        // banked rom, bank 0
    send_access(FUNC_WRITE, {BANK_PAGE, 12'h000}, 8'hFF);
    send_access(FUNC_READ,  16'h7FFF, 8'h00);       // top banked rom byte
    send_access(FUNC_READ,  PRG_LO, 8'h00);         // fixed bank
    send_access(FUNC_READ,  16'hFFFF, 8'h00);
    send_access(FUNC_READ,  WIN_LO - 16'd1, 8'h00); // just below the ram window
    send_access(FUNC_READ,  WIN_LO, 8'h00);         // cleared ram
    send_access(FUNC_READ,  WIN_HI - 16'd1, 8'h00);
    send_access(FUNC_READ,  WIN_HI, 8'h00);         // just past the window
    send_access(FUNC_WRITE, WIN_LO, 8'hFF);
    send_access(FUNC_WRITE, WIN_HI - 16'd1, 8'hA5);
    send_access(FUNC_READ,  WIN_LO, 8'h00);
    send_access(FUNC_READ,  WIN_HI - 16'd1, 8'h00);
    send_access(FUNC_WRITE, 16'h1234, 8'h55);       // ignored write
    send_access(FUNC_WRITE, 16'h7000, 8'hFF);       // ignored write in rom space
    send_access(FUNC_TICK,  16'hFFFF, 8'hFF);       // disabled tick
    send_access(FUNC_UNUSED, 16'hFFFF, 8'hFF);
    send_access(FUNC_WRITE, {IRQ_PAGE, 12'hFFF}, 8'h02);
    send_access(FUNC_TICK,  16'h0000, 8'h00);
    send_access(FUNC_TICK,  16'h0000, 8'h00);
    send_access(FUNC_WRITE, {IRQ_PAGE, 12'h000}, 8'hFD); // enable bit clear
    send_access(FUNC_TICK,  16'h0000, 8'h00);
    send_access(FUNC_WRITE, {BANK_PAGE, 12'h123}, 8'h00);

    // random phases, each with its own target and idle pattern
    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: target = 16'hFFFF;
        1: target = 16'd1;
        5: target = 16'($urandom);
        default: target = 16'($urandom_range(2, 40));
      endcase
      write_target(target);
      case (phase % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_gap_pct = 30; rx_stall_pct = 30; end
      endcase
      repeat (220) random_access();
    end

    drain();
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/cbm_pkg.sv
sv/cbm_decode.sv
sv/cbm_irq_timer.sv
sv/cbm_ram.sv
sv/cartridge_bank_mapper_with_irq_timer_unit.sv
sim/mapper_scoreboard_pkg.sv
sim/cartridge_bank_mapper_with_irq_timer_unit_tb.sv
